// ----- hdl/chss_pkg.sv -----
package chss_pkg;

    localparam int OUT_OFFSET_BITS = 48;
    localparam int INDEX_BITS      = 16;

    // Seven leading bytes of the container sync word
    localparam logic [55:0] MAGIC_HEAD = 56'h1F5453564D5441;
    localparam logic [7:0]  SYNC_V     = 8'h56;
    localparam logic [7:0]  SYNC_P     = 8'h50;

    // Packet type codes
    localparam logic [7:0]  TYPE_RESYNC = 8'h1F;
    localparam logic [7:0]  TYPE_NOP_FE = 8'hFE;
    localparam logic [7:0]  TYPE_NOP_FF = 8'hFF;

    typedef enum logic [1:0] {
        MODE_SEARCH,
        MODE_SKIP,
        MODE_TYPE,
        MODE_SIZE
    } scan_mode_t;

    typedef struct packed {
        logic [OUT_OFFSET_BITS-1:0] header_offset;
        logic [INDEX_BITS-1:0]      header_index;
    } header_t;

endpackage

// ----- hdl/chss_if.sv -----
interface chss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface chss_header_if;
    logic        valid;
    logic        ready;
    logic [47:0] header_offset;
    logic [15:0] header_index;

    modport source (output valid, output header_offset, output header_index, input ready);
    modport sink (input valid, input header_offset, input header_index, output ready);
endinterface

// ----- hdl/container_header_sync_scanner.sv -----
// Container header sync scanner.
// Channel stream carries one byte of the concatenated stream per transaction.
// Channel header carries one result per sync word found: the offset of its
// first byte (wrapping at OFFSET_BITS) and the zero-based header count,
// saturating at its maximum.
// The result is registered: the transaction carrying the final sync byte
// ('V' or 'P') loads it into the output register, or into the skid register
// while the output register is full and not taken. Throughput: one byte per
// clock while the skid register is empty; results never exceed one per byte.
// Between the scanner and the header channel sit an output register and a
// one-entry skid register. When the receiver stalls, results collect there;
// stream.ready drops only while the skid register is full, and rises again
// the cycle after the receiver takes a result.
// Reset puts the scanner in search mode with an empty window, byte offset
// zero and header count zero, and empties both result registers.
module container_header_sync_scanner #(
    parameter int HEADER_BYTES = 32,
    parameter int OFFSET_BITS  = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    chss_byte_if.sink     stream,
    chss_header_if.source header
);
    import chss_pkg::*;

    logic    accept;
    logic    hit;
    header_t hit_data;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    header_t out_data_reg, out_data_next;
    header_t skid_data_reg, skid_data_next;
    logic    pop;

    assign stream.ready = !skid_valid_reg;
    assign accept       = stream.valid && stream.ready;

    chss_core #(
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream.stream_byte),
        .hit         (hit),
        .hit_data    (hit_data)
    );

    assign pop = out_valid_reg && header.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid entry first, keep order
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = hit;
                skid_data_next  = hit_data;
            end
            else
            begin
                out_valid_next = hit;
                out_data_next  = hit_data;
            end
        end
        else if (hit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = hit_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign header.valid         = out_valid_reg;
    assign header.header_offset = out_data_reg.header_offset;
    assign header.header_index  = out_data_reg.header_index;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_hit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !hit)
        else $error("result produced while both result registers are full");

    a_hit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> out_valid_reg)
        else $error("result lost after a sync match");

endmodule

// ----- hdl/chss_core.sv -----
module chss_core #(
    parameter int HEADER_BYTES = 32,
    parameter int OFFSET_BITS  = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        stream_byte,
    output logic              hit,
    output chss_pkg::header_t hit_data
);
    import chss_pkg::*;

    localparam logic [31:0] HDR_SKIP = 32'(HEADER_BYTES - 8);

    scan_mode_t             mode_reg, mode_next;
    logic [55:0]            window_reg, window_next;
    logic [2:0]             fill_reg, fill_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [31:0]            skip_reg, skip_next;
    logic [23:0]            size_reg, size_next;
    logic [1:0]             size_cnt_reg, size_cnt_next;
    logic [INDEX_BITS-1:0]  index_reg, index_next;

    logic                   sync_match;
    logic [OFFSET_BITS-1:0] start_pos;
    logic [31:0]            new_size;

    assign sync_match = (fill_reg == 3'd7) && (window_reg == MAGIC_HEAD)
                     && (stream_byte == SYNC_V || stream_byte == SYNC_P);
    assign start_pos  = pos_reg - OFFSET_BITS'(7);
    assign new_size   = {stream_byte, size_reg};

    assign hit                    = accept && (mode_reg == MODE_SEARCH) && sync_match;
    assign hit_data.header_offset = OUT_OFFSET_BITS'(start_pos);
    assign hit_data.header_index  = index_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        window_next   = window_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        skip_next     = skip_reg;
        size_next     = size_reg;
        size_cnt_next = size_cnt_reg;
        index_next    = index_reg;
        if (accept)
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            unique case (mode_reg)
                MODE_SEARCH:
                begin
                    window_next = {window_reg[47:0], stream_byte};
                    fill_next   = (fill_reg == 3'd7) ? fill_reg : fill_reg + 3'd1;
                    if (sync_match)
                    begin
                        if (index_reg != '1)
                            index_next = index_reg + INDEX_BITS'(1);
                        fill_next = '0;
                        skip_next = HDR_SKIP;
                        mode_next = (HDR_SKIP != '0) ? MODE_SKIP : MODE_TYPE;
                    end
                end
                MODE_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg <= 32'd1)
                        mode_next = MODE_TYPE;
                end
                MODE_TYPE:
                begin
                    if (stream_byte == TYPE_RESYNC)
                    begin
                        // restart the search with this byte already in the window
                        window_next = {48'd0, stream_byte};
                        fill_next   = 3'd1;
                        mode_next   = MODE_SEARCH;
                    end
                    else if (stream_byte != TYPE_NOP_FE && stream_byte != TYPE_NOP_FF)
                    begin
                        size_cnt_next = '0;
                        mode_next     = MODE_SIZE;
                    end
                end
                MODE_SIZE:
                begin
                    size_cnt_next = size_cnt_reg + 2'd1;
                    case (size_cnt_reg)
                        2'd0: size_next[7:0]   = stream_byte;
                        2'd1: size_next[15:8]  = stream_byte;
                        2'd2: size_next[23:16] = stream_byte;
                        default:
                        begin
                            skip_next = new_size;
                            mode_next = (new_size != '0) ? MODE_SKIP : MODE_TYPE;
                        end
                    endcase
                end
                default: mode_next = MODE_SEARCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SEARCH;
            fill_reg     <= '0;
            pos_reg      <= '0;
            skip_reg     <= '0;
            size_cnt_reg <= '0;
            index_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            size_cnt_reg <= size_cnt_next;
            index_reg    <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        size_reg   <= size_next;
    end

    a_hit_leaves_search: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (mode_reg == MODE_SKIP || mode_reg == MODE_TYPE) && fill_reg == '0)
        else $error("sync match did not leave search mode");

    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pos_reg == $past(pos_reg) + OFFSET_BITS'(1))
        else $error("byte position did not advance on a transaction");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !hit |=> index_reg == $past(index_reg))
        else $error("header index moved without a match");

endmodule
